>>> rtl/nmb_pkg.sv
// ---------------------------------------------------------------------------
// Neighbour mean blur package
// Shared widths, register codes, pixel and run types, and the constant divider
// used by the averaging lanes.
// ---------------------------------------------------------------------------
package nmb_pkg;

   // Field widths
   localparam int PIX_W      = 8;
   localparam int FW_W       = 12;
   localparam int FH_W       = 13;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Frame limits and register reset values
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 4096;
   localparam int MIN_DIM       = 2;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic            THREE_CHAN_RST   = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_THREE_CHANNEL = 2'd2
   } csr_index_type;

   // Lanes: one per output position that a pixel can complete
   localparam int NUM_LANES  = 4;
   localparam int LANE_IDX_W = 2;
   localparam int SUM_W      = PIX_W + 3;

   // Reciprocal constants, exact for sums below 2048
   localparam int RECIP3 = 1366;
   localparam int SHIFT3 = 12;
   localparam int RECIP5 = 1639;
   localparam int SHIFT5 = 13;
   localparam int SHIFT8 = 3;
   localparam int PROD_W = SUM_W + 11;

   // Run queue
   localparam int RUN_DEPTH = 8;
   localparam int RUN_AW    = $clog2(RUN_DEPTH);
   localparam int PTR_W     = RUN_AW + 1;

   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
   } pixel_type;

   // Which neighbour rows and columns lie inside the frame
   typedef struct packed {
      logic top;
      logic bot;
      logic left;
      logic right;
   } nb_type;

   typedef enum logic [1:0] {
      DIV3,
      DIV5,
      DIV8
   } div_type;

   // All results caused by one pixel
   typedef struct packed {
      logic [ROW_W-1:0]            row;
      logic [OUT_COL_W-1:0]        col;
      logic [NUM_LANES-1:0]        mask;
      pixel_type [NUM_LANES-1:0]   mean;
   } run_type;

   // Truncated mean of a neighbour sum over 3, 5 or 8 cells
   function automatic logic [PIX_W-1:0] div_mean(input logic [SUM_W-1:0] sum,
                                                 input div_type div);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] quot;
      prod = '0;
      quot = '0;
      case (div)
         DIV3: begin
            prod = PROD_W'(sum) * PROD_W'(RECIP3);
            quot = prod >> SHIFT3;
         end
         DIV5: begin
            prod = PROD_W'(sum) * PROD_W'(RECIP5);
            quot = prod >> SHIFT5;
         end
         default: begin
            quot = PROD_W'(sum) >> SHIFT8;
         end
      endcase
      return quot[PIX_W-1:0];
   endfunction

endpackage

>>> rtl/nmb_ifs.sv
// ---------------------------------------------------------------------------
// Neighbour mean blur channels
// Valid/ready channels for incoming pixels and outgoing mean words.
// ---------------------------------------------------------------------------
interface nmb_req_if import nmb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_b;
   logic [PIX_W-1:0] pixel_g;
   logic [PIX_W-1:0] pixel_r;

   modport source (output valid, output pixel_b, output pixel_g, output pixel_r,
                   input ready);
   modport sink   (input valid, input pixel_b, input pixel_g, input pixel_r,
                   output ready);
endinterface

interface nmb_rsp_if import nmb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     out_row;
   logic [OUT_COL_W-1:0] out_col;
   logic [PIX_W-1:0]     mean_b;
   logic [PIX_W-1:0]     mean_g;
   logic [PIX_W-1:0]     mean_r;
   logic                 last_of_run;
   logic                 frame_done;

   modport source (output valid, output out_row, output out_col, output mean_b,
                   output mean_g, output mean_r, output last_of_run,
                   output frame_done, input ready);
   modport sink   (input valid, input out_row, input out_col, input mean_b,
                   input mean_g, input mean_r, input last_of_run,
                   input frame_done, output ready);
endinterface

>>> rtl/neighbor_mean_blur_3x3_top.sv
// ---------------------------------------------------------------------------
// Neighbour mean blur, 3x3
// Streaming mean of the in-frame 3x3 neighbours of each pixel, centre excluded,
// with two line stores, a 3x3 window, four averaging lanes and a merge stage.
// ---------------------------------------------------------------------------
// Usage
// Pixels enter on req_bus in raster order, one word per pixel. Mean words leave
// on rsp_bus tagged with their row and column. Output (r,c) is produced when
// pixel (r+1,c+1) arrives, clamped at the frame edge, so a pixel gives zero to
// four words; last_of_run marks the final word of a pixel and frame_done the
// bottom-right pixel of the frame.
// A pixel passes the stage 1, window, lane sum and run queue registers in turn.
// Throughput: one pixel per cycle while the run queue has room; the output
// sends one word per cycle while rsp_bus.ready is high, and the extra words
// of a pixel closing a row or frame wait there. An eight-run queue feeding
// rsp_bus sets how far the output may fall behind before req_bus.ready drops.
// Reset returns the frame position to row 0, column 0 and the registers to a
// 640 x 480 three-channel frame; the line stores are not cleared.
// When the receiver stalls, words wait in the run queue and req_bus.ready
// falls once eight pixels with results are outstanding.
// The user writes registers through csr_* only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module neighbor_mean_blur_3x3_top import nmb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   nmb_req_if.sink               req_bus,
   nmb_rsp_if.source             rsp_bus
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WV_W  = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

   // Registers
   logic [FW_W-1:0]  frame_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic             three_channel_ff;
   logic [WV_W-1:0]  eff_w;
   logic [FH_W-1:0]  eff_h;

   // Frame position
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             wrap0;
   logic [COL_W-1:0] c_cur;
   logic [FH_W-1:0]  r_tmp;
   logic [FH_W-1:0]  r_cur13;
   logic [ROW_W-1:0] r_cur;
   logic [WV_W-1:0]  c_inc;
   logic [FH_W-1:0]  r_inc;
   logic             row_end;
   logic             col_last, row_last, col_pos, row_pos;
   logic [ROW_W-1:0] rm1;
   logic [COL_W-1:0] cm1;
   logic [NUM_LANES-1:0] mask_s0;
   nb_type           nb_s0 [NUM_LANES];
   logic             accept;
   logic             run_room;

   // Pipeline
   logic                 s1_valid_ff;
   logic [ROW_W-1:0]     s1_row_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [NUM_LANES-1:0] s1_mask_ff;
   nb_type               s1_nb_ff [NUM_LANES];
   pixel_type            s1_px_ff;
   pixel_type            up2, up1;
   pixel_type            window_ff [3][3];
   pixel_type            window_in [3][3];
   logic [ROW_W-1:0]     s2_row_ff;
   logic [OUT_COL_W-1:0] s2_col_ff;
   logic [NUM_LANES-1:0] s2_mask_ff;
   nb_type               s2_nb_ff [NUM_LANES];
   logic [ROW_W-1:0]     s3_row_ff;
   logic [OUT_COL_W-1:0] s3_col_ff;
   logic [NUM_LANES-1:0] s3_mask_ff;
   pixel_type            lane_avg [NUM_LANES];
   run_type              push_run;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         three_channel_ff <= THREE_CHAN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_wr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_wr_data[FH_W-1:0];
            CSR_THREE_CHANNEL: three_channel_ff <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the frame size to the supported range
   always_comb begin
      if (WV_W'(frame_width_ff) < WV_W'(MIN_DIM)) begin
         eff_w = WV_W'(MIN_DIM);
      end else if (WV_W'(frame_width_ff) > WV_W'(MAX_WIDTH)) begin
         eff_w = WV_W'(MAX_WIDTH);
      end else begin
         eff_w = WV_W'(frame_width_ff);
      end
      if (frame_height_ff < FH_W'(MIN_DIM)) begin
         eff_h = FH_W'(MIN_DIM);
      end else if (frame_height_ff > FH_W'(MAX_HEIGHT)) begin
         eff_h = FH_W'(MAX_HEIGHT);
      end else begin
         eff_h = frame_height_ff;
      end
   end

   // Position of the pixel on offer, its successor and the outputs it completes
   always_comb begin
      wrap0   = (WV_W'(col_ff) >= eff_w);
      c_cur   = wrap0 ? '0 : col_ff;
      r_tmp   = FH_W'(row_ff) + FH_W'(wrap0);
      r_cur13 = (r_tmp >= eff_h) ? '0 : r_tmp;
      r_cur   = r_cur13[ROW_W-1:0];

      c_inc   = WV_W'(c_cur) + WV_W'(1);
      row_end = (c_inc >= eff_w);
      r_inc   = FH_W'(r_cur) + FH_W'(1);
      col_in  = row_end ? '0 : c_inc[COL_W-1:0];
      if (!row_end) begin
         row_in = r_cur;
      end else if (r_inc >= eff_h) begin
         row_in = '0;
      end else begin
         row_in = r_inc[ROW_W-1:0];
      end

      col_last = (WV_W'(c_cur) == eff_w - WV_W'(1));
      row_last = (FH_W'(r_cur) == eff_h - FH_W'(1));
      col_pos  = (c_cur != '0);
      row_pos  = (r_cur != '0);
      // Lane order: up-left, up, left, here
      mask_s0  = {row_last & col_last, row_last & col_pos,
                  row_pos & col_last, row_pos & col_pos};

      // Frame edges around each lane's centre
      rm1 = r_cur - ROW_W'(1);
      cm1 = c_cur - COL_W'(1);
      nb_s0[0] = '{top: (rm1 != '0), bot: (FH_W'(rm1) != eff_h - FH_W'(1)),
                   left: (cm1 != '0), right: (WV_W'(cm1) != eff_w - WV_W'(1))};
      nb_s0[1] = '{top: (rm1 != '0), bot: (FH_W'(rm1) != eff_h - FH_W'(1)),
                   left: col_pos, right: !col_last};
      nb_s0[2] = '{top: row_pos, bot: !row_last,
                   left: (cm1 != '0), right: (WV_W'(cm1) != eff_w - WV_W'(1))};
      nb_s0[3] = '{top: row_pos, bot: !row_last, left: col_pos, right: !col_last};
   end

   assign req_bus.ready = run_room;
   assign accept        = req_bus.valid && req_bus.ready;

   // Advance the frame position on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores: read at acceptance, write back in the following cycle
   nmb_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_store_older (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (up1),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (up2)
   );

   nmb_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_store_newer (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (up1)
   );

   // Stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_mask_ff  <= '0;
      end else begin
         s1_valid_ff <= accept;
         s1_mask_ff  <= accept ? mask_s0 : '0;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff  <= r_cur;
         s1_col_ff  <= c_cur;
         s1_nb_ff   <= nb_s0;
         s1_px_ff.b <= req_bus.pixel_b;
         s1_px_ff.g <= req_bus.pixel_g;
         s1_px_ff.r <= req_bus.pixel_r;
      end
   end

   // Shift the window left and load the new column
   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            window_in[i][0] = window_ff[i][1];
            window_in[i][1] = window_ff[i][2];
         end
         window_in[0][2] = up2;
         window_in[1][2] = up1;
         window_in[2][2] = s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               window_ff[i][j] <= '0;
            end
         end
      end else begin
         window_ff <= window_in;
      end
   end

   // Stages 2 and 3 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
         s3_mask_ff <= '0;
      end else begin
         s2_mask_ff <= s1_mask_ff;
         s3_mask_ff <= s2_mask_ff;
      end
   end

   // Stages 2 and 3 payload
   always_ff @(posedge clock) begin
      s2_row_ff <= s1_row_ff;
      s2_col_ff <= OUT_COL_W'(s1_col_ff);
      s2_nb_ff  <= s1_nb_ff;
      s3_row_ff <= s2_row_ff;
      s3_col_ff <= s2_col_ff;
   end

   // Averaging lanes, one per window centre
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      localparam int WR = 1 + k / 2;
      localparam int WC = 1 + k % 2;
      pixel_type nbhd [3][3];

      for (genvar di = 0; di < 3; di++) begin : g_row
         for (genvar dj = 0; dj < 3; dj++) begin : g_col
            if (WR + di - 1 <= 2 && WC + dj - 1 <= 2) begin : g_in
               assign nbhd[di][dj] = window_ff[WR + di - 1][WC + dj - 1];
            end else begin : g_out
               assign nbhd[di][dj] = '0;
            end
         end
      end

      nmb_lane u_lane (
         .clock (clock),
         .win   (nbhd),
         .nb    (s2_nb_ff[k]),
         .mean  (lane_avg[k])
      );
   end

   // Gather the lane results into one run
   always_comb begin
      push_run.row  = s3_row_ff;
      push_run.col  = s3_col_ff;
      push_run.mask = s3_mask_ff;
      for (int k = 0; k < NUM_LANES; k++) begin
         push_run.mean[k] = lane_avg[k];
      end
   end

   nmb_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .reserve       (accept && (mask_s0 != '0)),
      .push          (s3_mask_ff != '0),
      .push_run      (push_run),
      .three_channel (three_channel_ff),
      .room          (run_room),
      .rsp_bus       (rsp_bus)
   );

endmodule

>>> rtl/nmb_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module nmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nmb_lane.sv
// ---------------------------------------------------------------------------
// Neighbour mean lane
// Sums the in-frame neighbours of one 3x3 neighbourhood per channel, registers
// the sums, then divides by 3 or 5 through a reciprocal multiply, or by 8 through a shift.
// ---------------------------------------------------------------------------
module nmb_lane import nmb_pkg::*; (
   input  logic      clock,
   input  pixel_type win [3][3],
   input  nb_type    nb,
   output pixel_type mean
);

   logic [SUM_W-1:0] sum_b_in, sum_g_in, sum_r_in;
   logic [SUM_W-1:0] sum_b_ff, sum_g_ff, sum_r_ff;
   div_type          div_in, div_ff;
   logic             use_cell;

   // Add the neighbours that lie in the frame, centre excluded
   always_comb begin
      sum_b_in = '0;
      sum_g_in = '0;
      sum_r_in = '0;
      use_cell = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            use_cell = !(i == 1 && j == 1) &&
                       (i != 0 || nb.top) && (i != 2 || nb.bot) &&
                       (j != 0 || nb.left) && (j != 2 || nb.right);
            if (use_cell) begin
               sum_b_in = sum_b_in + SUM_W'(win[i][j].b);
               sum_g_in = sum_g_in + SUM_W'(win[i][j].g);
               sum_r_in = sum_r_in + SUM_W'(win[i][j].r);
            end
         end
      end
      // Full rows and columns of neighbours: 8 inside, 5 on an edge, 3 at a corner
      if (nb.top && nb.bot && nb.left && nb.right) begin
         div_in = DIV8;
      end else if ((nb.top && nb.bot) || (nb.left && nb.right)) begin
         div_in = DIV5;
      end else begin
         div_in = DIV3;
      end
   end

   // Hold sums for the divide stage
   always_ff @(posedge clock) begin
      sum_b_ff <= sum_b_in;
      sum_g_ff <= sum_g_in;
      sum_r_ff <= sum_r_in;
      div_ff   <= div_in;
   end

   // Divide by the neighbour count
   always_comb begin
      mean.b = div_mean(sum_b_ff, div_ff);
      mean.g = div_mean(sum_g_ff, div_ff);
      mean.r = div_mean(sum_r_ff, div_ff);
   end

endmodule

>>> rtl/nmb_merge.sv
// ---------------------------------------------------------------------------
// Neighbour mean merge stage
// Queues the lane results of each pixel as one run and sends its valid lanes out
// in lane order, one word per cycle while rsp_bus.ready is high, marking the last word of each run.
// ---------------------------------------------------------------------------
module nmb_merge import nmb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     reserve,
   input  logic     push,
   input  run_type  push_run,
   input  logic     three_channel,
   output logic     room,
   nmb_rsp_if.source rsp_bus
);

   run_type               run_ff [RUN_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]      credit_ff, credit_in;
   logic [NUM_LANES-1:0]  sent_ff, sent_in;
   run_type               head;
   logic [NUM_LANES-1:0]  remain;
   logic [NUM_LANES-1:0]  sel_oh;
   logic [LANE_IDX_W-1:0] sel;
   logic                  last;
   logic                  empty;
   logic                  pop_word;
   logic                  run_done;
   pixel_type             avg;

   // Pick the lowest lane not yet sent from the head run
   always_comb begin
      head     = run_ff[rd_ptr_ff[RUN_AW-1:0]];
      empty    = (wr_ptr_ff == rd_ptr_ff);
      remain   = head.mask & ~sent_ff;
      sel_oh   = remain & (~remain + NUM_LANES'(1));
      sel      = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (sel_oh[k]) begin
            sel = LANE_IDX_W'(k);
         end
      end
      last     = ((remain & ~sel_oh) == '0);
      pop_word = !empty && rsp_bus.ready;
      run_done = pop_word && last;

      sent_in = sent_ff;
      if (run_done) begin
         sent_in = '0;
      end else if (pop_word) begin
         sent_in = sent_ff | sel_oh;
      end
      rd_ptr_in = rd_ptr_ff + PTR_W'(run_done);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push);
      // A run slot is held from pixel acceptance until its last word leaves
      credit_in = credit_ff + PTR_W'(reserve) - PTR_W'(run_done);
      room      = (credit_ff < PTR_W'(RUN_DEPTH));
   end

   // Drive the word: lanes 0 and 1 sit one row up, lanes 0 and 2 one column left
   always_comb begin
      avg                 = head.mean[sel];
      rsp_bus.valid       = !empty;
      rsp_bus.out_row     = sel[1] ? head.row : head.row - ROW_W'(1);
      rsp_bus.out_col     = sel[0] ? head.col : head.col - OUT_COL_W'(1);
      rsp_bus.mean_b      = avg.b;
      rsp_bus.mean_g      = three_channel ? avg.g : '0;
      rsp_bus.mean_r      = three_channel ? avg.r : '0;
      rsp_bus.last_of_run = last;
      rsp_bus.frame_done  = (sel == LANE_IDX_W'(NUM_LANES - 1));
   end

   // Store incoming runs
   always_ff @(posedge clock) begin
      if (push) begin
         run_ff[wr_ptr_ff[RUN_AW-1:0]] <= push_run;
      end
   end

   // Advance pointers and credit
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         credit_ff <= '0;
         sent_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         credit_ff <= credit_in;
         sent_ff   <= sent_in;
      end
   end

endmodule
